>>> sv/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared constants and types for the stable priority queue and its cells.
// ============================================================================
package spq_pkg;

  // Number of entries that the queue holds.
  localparam int unsigned QueueDepth = 16;

  // Width of the entry count, wide enough to hold QueueDepth itself.
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam int unsigned DataW = 32;
  localparam int unsigned PrioW = 8;
  localparam int unsigned OccW  = 5;

  // Operation codes on the op field.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_EXTRACTED = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_INSERTED  = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // Data word reported when no entry is returned.
  localparam logic signed [DataW-1:0] NO_DATA = '1;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic                    do_insert;
    logic                    do_extract;
    logic signed [DataW-1:0] new_data;
    logic [PrioW-1:0]        new_prio;
  } cell_ctrl_t;

endpackage

>>> sv/spq_cell.sv
// ============================================================================
// spq_cell
// One slot of the sorted row: holds an entry and trades it with its
// neighbors on insert and extract.
// ============================================================================
module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           valid_i,
  input  logic                           left_keep_i,
  input  logic signed [spq_pkg::DataW-1:0] left_data_i,
  input  logic [spq_pkg::PrioW-1:0]      left_prio_i,
  input  logic signed [spq_pkg::DataW-1:0] right_data_i,
  input  logic [spq_pkg::PrioW-1:0]      right_prio_i,
  output logic                           keep_o,
  output logic signed [spq_pkg::DataW-1:0] data_o,
  output logic [spq_pkg::PrioW-1:0]      prio_o
);
  import spq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic [PrioW-1:0]        prio_q, prio_d;

  // The entry stays in place on insert when it is as urgent as the new item
  // or more. Since the row is sorted, these cells form a prefix.
  assign keep_o = valid_i && (prio_q <= ctrl_i.new_prio);

  // Next entry: stay, take the new item at the boundary, shift toward the
  // back on insert, or shift toward the front on extract.
  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.do_insert && !keep_o) begin
      if (left_keep_i) begin
        data_d = ctrl_i.new_data;
        prio_d = ctrl_i.new_prio;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.do_extract) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

>>> sv/stable_priority_queue.sv
// A result is registered when its item is accepted and appears in the cycle
// after. Throughput: one insert or extract per cycle while the result output
// is not stalled; every cell of the row compares and shifts in the same
// cycle, so the next item may follow at once. Reset: asynchronous, active low;
// it empties the queue and the result register. Entry storage is not cleared,
// only entries below the count are ever read.
// ============================================================================
// stable_priority_queue
// Bounded priority queue kept as a sorted row of cells; ties leave in
// arrival order.
// ============================================================================
module stable_priority_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic signed [spq_pkg::DataW-1:0] data_in_i,
  input  logic [spq_pkg::PrioW-1:0]        priority_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [spq_pkg::DataW-1:0] data_out_o,
  output logic [1:0]                       status_o,
  output logic [spq_pkg::OccW-1:0]         occupancy_o
);
  import spq_pkg::*;

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  cell_ctrl_t              ctrl;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW+OccW-1:0]    count_ext;
  logic                    out_valid_q;
  logic signed [DataW-1:0] data_out_q, data_out_d;
  logic [1:0]              status_q, status_d;
  logic [OccW-1:0]         occ_q;

  logic                    keep_arr [QueueDepth];
  logic signed [DataW-1:0] data_arr [QueueDepth];
  logic [PrioW-1:0]        prio_arr [QueueDepth];

  // An item enters when the result register is free or is being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CntW'(QueueDepth));
  assign is_empty = (count_q == '0);

  // Control broadcast to the row.
  always_comb begin
    ctrl.do_insert  = accept && (op_i == OP_INSERT) && !is_full;
    ctrl.do_extract = accept && (op_i == OP_EXTRACT) && !is_empty;
    ctrl.new_data   = data_in_i;
    ctrl.new_prio   = priority_in_i;
  end

  // Row of cells, front entry in cell zero.
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    logic                    left_keep;
    logic signed [DataW-1:0] left_data;
    logic [PrioW-1:0]        left_prio;
    logic signed [DataW-1:0] right_data;
    logic [PrioW-1:0]        right_prio;
    logic                    cell_valid;

    assign cell_valid = (CntW'(g) < count_q);

    if (g == 0) begin : g_front
      assign left_keep = 1'b1;
      assign left_data = data_in_i;
      assign left_prio = priority_in_i;
    end else begin : g_mid
      assign left_keep = keep_arr[g-1];
      assign left_data = data_arr[g-1];
      assign left_prio = prio_arr[g-1];
    end

    if (g == QueueDepth - 1) begin : g_back
      assign right_data = data_arr[g];
      assign right_prio = prio_arr[g];
    end else begin : g_inner
      assign right_data = data_arr[g+1];
      assign right_prio = prio_arr[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid),
      .left_keep_i  (left_keep),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .keep_o       (keep_arr[g]),
      .data_o       (data_arr[g]),
      .prio_o       (prio_arr[g])
    );
  end

  // Entry count and the result of the accepted item.
  always_comb begin
    count_d    = count_q;
    data_out_d = NO_DATA;
    status_d   = STATUS_INSERTED;
    if (op_i == OP_INSERT) begin
      if (is_full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        status_d   = STATUS_EXTRACTED;
        data_out_d = data_arr[0];
        count_d    = count_q - CntW'(1);
      end
    end
  end

  // Occupancy carries the low bits of the count.
  assign count_ext = {{OccW{1'b0}}, count_d};

  // Count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_out_q <= data_out_d;
      status_q   <= status_d;
      occ_q      <= count_ext[OccW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

>>> sv/spq_checker.sv
// ============================================================================
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ============================================================================
module spq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             op_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [spq_pkg::DataW-1:0] data_out_o,
  input logic [1:0]                       status_o,
  input logic [spq_pkg::OccW-1:0]         occupancy_o
);
  import spq_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(data_out_o) && $stable(status_o) && $stable(occupancy_o)))
    else $error("stalled result changed");

  // An accepted insert is answered with an inserted or full status.
  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == OP_INSERT) |=>
      (out_valid_o && (status_o == STATUS_INSERTED || status_o == STATUS_FULL)))
    else $error("insert did not give an insert status");

  // An accepted extract is answered with an extracted or empty status.
  a_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == OP_EXTRACT) |=>
      (out_valid_o && (status_o == STATUS_EXTRACTED || status_o == STATUS_EMPTY)))
    else $error("extract did not give an extract status");

  // An empty extract leaves nothing in the queue.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

  // Only an extracted item carries a data word.
  a_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_EXTRACTED) |-> (data_out_o == NO_DATA))
    else $error("data word on a result without an extracted item");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .data_out_o  (data_out_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);
